// ===== sv/krs_pkg.sv =====
// ----------------------------------------------------------------------------
// krs_pkg: shared definitions for keypoint radius suppression
// Widths, channel payload types, cell control codes and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package krs_pkg;

   // Store depth and response precision.
   localparam int MAX_POINTS    = 64;
   localparam int RESPONSE_BITS = 16;

   // Fixed field widths of the channels and registers.
   localparam int POS_W       = 12;
   localparam int LVL_W       = 2;
   localparam int RESP_IN_W   = 16;
   localparam int OUT_IDX_W   = 6;
   localparam int KEEP_W      = 7;
   localparam int RAD_W       = 13;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 13;

   // Derived widths.
   localparam int IDX_W   = $clog2(MAX_POINTS);
   localparam int CNT_W   = $clog2(MAX_POINTS + 1);
   localparam int KSTEP_W = $clog2(MAX_POINTS + 2);
   localparam int COORD_W = POS_W + (1 << LVL_W) - 1;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int SQ_W    = 2 * COORD_W;
   localparam int DIST_W  = SQ_W + 1;
   localparam int KILL_W  = DIST_W + 1;
   localparam int RR_W    = 2 * (RAD_W - 1) + 1;
   localparam int PROD_W  = RESPONSE_BITS + 4;
   localparam int CMP_W   = (CNT_W > KEEP_W) ? CNT_W + 1 : KEEP_W + 1;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_KEEP_COUNT   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_LIMIT = 1'b1;

   // Reset values of the configuration registers.
   localparam logic [KEEP_W-1:0] KEEP_COUNT_RST   = 7'd16;
   localparam logic [RAD_W-1:0]  RADIUS_LIMIT_RST = 13'd512;

   // One stored keypoint.
   typedef struct packed {
      logic [POS_W-1:0]         x;
      logic [POS_W-1:0]         y;
      logic [LVL_W-1:0]         lvl;
      logic [RESPONSE_BITS-1:0] resp;
   } point_type;

   // A keypoint travelling around the ring of cells.
   typedef struct packed {
      logic      valid;
      point_type pt;
   } trav_type;

   // A radius probe travelling down the chain, counting survivors.
   typedef struct packed {
      logic             valid;
      logic             last;
      logic [RR_W-1:0]  rr;
      logic [CNT_W-1:0] cnt;
   } srch_type;

   // Operations broadcast to every cell.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_START,
      OP_ROTATE,
      OP_SEARCH,
      OP_KEEP_ALL,
      OP_KEEP_NONE,
      OP_KEEP_RR,
      OP_SHIFT
   } cell_op_type;

   // Control group from the sequencer to the cells.
   typedef struct packed {
      cell_op_type      op;
      logic             load_en;
      logic [IDX_W-1:0] load_idx;
      point_type        load_pt;
      logic [RR_W-1:0]  sel_rr;
   } cell_ctrl_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_KILL,
      ST_SEARCH,
      ST_MARK,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

// ===== sv/krs_if.sv =====
// ----------------------------------------------------------------------------
// krs_if: keypoint and keep-flag channels
// Valid/ready channels carrying one keypoint or one keep flag per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface krs_req_if;
   import krs_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [POS_W-1:0]     pos_x;
   logic [POS_W-1:0]     pos_y;
   logic [LVL_W-1:0]     level;
   logic [RESP_IN_W-1:0] response;
   logic                 final_point;

   modport source (output valid, pos_x, pos_y, level, response, final_point,
                   input ready);
   modport sink   (input valid, pos_x, pos_y, level, response, final_point,
                   output ready);
endinterface

interface krs_rsp_if;
   import krs_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [OUT_IDX_W-1:0] point_index;
   logic                 keep;
   logic                 last_result;

   modport source (output valid, point_index, keep, last_result, input ready);
   modport sink   (input valid, point_index, keep, last_result, output ready);
endinterface

`default_nettype wire

// ===== sv/krs_cell.sv =====
// ----------------------------------------------------------------------------
// krs_cell: one keypoint cell of the suppression chain
// Holds one keypoint, finds its suppression distance against the points that
// rotate past it, counts itself into radius probes and keeps its flag.
// ----------------------------------------------------------------------------
`default_nettype none

module krs_cell (
   input  wire                          clock,
   input  wire                          reset,
   input  wire [krs_pkg::IDX_W-1:0]     cell_id,
   input  krs_pkg::cell_ctrl_type       ctrl,
   input  krs_pkg::trav_type            trav_in,
   output krs_pkg::trav_type            trav_out,
   input  krs_pkg::srch_type            srch_in,
   output krs_pkg::srch_type            srch_out,
   input  wire                          keep_in,
   output logic                         keep_out
);
   import krs_pkg::*;

   point_type          own_ff, own_in;
   logic               pv_ff, pv_in;
   trav_type           trav_ff, trav_in_nx;
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_nb_ff, s1_nb_in;
   logic [SQ_W-1:0]    s1_sqx_ff, s1_sqx_in;
   logic [SQ_W-1:0]    s1_sqy_ff, s1_sqy_in;
   logic [KILL_W-1:0]  kill_ff, kill_in;
   srch_type           srch_ff, srch_in_nx;
   logic               keep_ff, keep_in_nx;

   logic [COORD_W-1:0]       ax, ay, bx, by;
   logic signed [DIFF_W-1:0] dx, dy;
   logic signed [2*DIFF_W-1:0] px, py;
   logic [PROD_W-1:0]        ten_own, nine_oth;
   logic [DIST_W-1:0]        pair_dist;

   // Real coordinates, differences and squares against the passing point.
   always_comb begin
      ax = COORD_W'(own_ff.x) << own_ff.lvl;
      ay = COORD_W'(own_ff.y) << own_ff.lvl;
      bx = COORD_W'(trav_ff.pt.x) << trav_ff.pt.lvl;
      by = COORD_W'(trav_ff.pt.y) << trav_ff.pt.lvl;
      dx = $signed({1'b0, ax}) - $signed({1'b0, bx});
      dy = $signed({1'b0, ay}) - $signed({1'b0, by});
      px = dx * dx;
      py = dy * dy;
      s1_sqx_in = SQ_W'(px);
      s1_sqy_in = SQ_W'(py);
      ten_own   = PROD_W'(own_ff.resp) * PROD_W'(10);
      nine_oth  = PROD_W'(trav_ff.pt.resp) * PROD_W'(9);
      s1_nb_in  = !(ten_own > nine_oth);
      s1_valid_in = (ctrl.op == OP_ROTATE) && trav_ff.valid && pv_ff;
      pair_dist = DIST_W'(s1_sqx_ff) + DIST_W'(s1_sqy_ff);
   end

   // Next state of the cell.
   always_comb begin
      own_in     = own_ff;
      pv_in      = pv_ff;
      trav_in_nx = trav_ff;
      kill_in    = kill_ff;
      srch_in_nx = srch_ff;
      keep_in_nx = keep_ff;

      // Loading; the first point of a set retires all others.
      if (ctrl.load_en) begin
         if (ctrl.load_idx == cell_id) begin
            own_in = ctrl.load_pt;
            pv_in  = 1'b1;
         end else if (ctrl.load_idx == '0) begin
            pv_in = 1'b0;
         end
      end

      // The nearest point that this one does not beat.
      if (s1_valid_ff && s1_nb_ff && (KILL_W'(pair_dist) < kill_ff)) begin
         kill_in = KILL_W'(pair_dist);
      end

      case (ctrl.op)
         OP_START: begin
            trav_in_nx.valid = pv_ff;
            trav_in_nx.pt    = own_ff;
            kill_in          = '1;
            srch_in_nx.valid = 1'b0;
         end
         OP_ROTATE: begin
            trav_in_nx = trav_in;
         end
         OP_SEARCH: begin
            srch_in_nx = srch_in;
            if (pv_ff && (KILL_W'(srch_in.rr) <= kill_ff)) begin
               srch_in_nx.cnt = srch_in.cnt + CNT_W'(1);
            end
         end
         OP_KEEP_ALL: begin
            keep_in_nx = pv_ff;
         end
         OP_KEEP_NONE: begin
            keep_in_nx = 1'b0;
         end
         OP_KEEP_RR: begin
            keep_in_nx = pv_ff && (KILL_W'(ctrl.sel_rr) <= kill_ff);
         end
         OP_SHIFT: begin
            keep_in_nx = keep_in;
         end
         default: begin
         end
      endcase
   end

   // Cell registers; only the control bits are reset.
   always_ff @(posedge clock) begin
      own_ff       <= own_in;
      trav_ff.pt   <= trav_in_nx.pt;
      s1_nb_ff     <= s1_nb_in;
      s1_sqx_ff    <= s1_sqx_in;
      s1_sqy_ff    <= s1_sqy_in;
      kill_ff      <= kill_in;
      srch_ff.last <= srch_in_nx.last;
      srch_ff.rr   <= srch_in_nx.rr;
      srch_ff.cnt  <= srch_in_nx.cnt;
      if (reset) begin
         pv_ff         <= 1'b0;
         trav_ff.valid <= 1'b0;
         s1_valid_ff   <= 1'b0;
         srch_ff.valid <= 1'b0;
         keep_ff       <= 1'b0;
      end else begin
         pv_ff         <= pv_in;
         trav_ff.valid <= trav_in_nx.valid;
         s1_valid_ff   <= s1_valid_in;
         srch_ff.valid <= srch_in_nx.valid;
         keep_ff       <= keep_in_nx;
      end
   end

   assign trav_out = trav_ff;
   assign srch_out = srch_ff;
   assign keep_out = keep_ff;

endmodule

`default_nettype wire

// ===== sv/keypoint_radius_suppression.sv =====
// ----------------------------------------------------------------------------
// keypoint_radius_suppression: adaptive non-maximal suppression of keypoints
// Loads a set of keypoints and reports one keep flag per keypoint.
// ----------------------------------------------------------------------------
// Usage:
// Keypoints arrive on req_chan, one per beat, one per cycle while loading.
// A beat with final_point set closes the set; the block then stops taking
// beats and answers with one beat per stored point on rsp_chan, in load order,
// last_result marking the final one. Points past 64 are dropped.
// After the final beat, a set that fits keep_count goes straight to marking;
// otherwise the ring rotates first (every cell meets every point),
// then one radius probe per cycle enters a 64-cell chain until a probe
// counts no more survivors than keep_count or reaches radius_limit.
// Results then leave one per cycle while rsp_chan is ready; a stalled
// receiver simply holds the current flag. The next set is taken after the
// last result beat. Reset empties the set and restores keep_count to 16 and
// radius_limit to 512. csr_* writes belong to idle periods only.
// ----------------------------------------------------------------------------
`default_nettype none

module keypoint_radius_suppression (
   input  wire                                clock,
   input  wire                                reset,
   krs_req_if.sink                            req_chan,
   krs_rsp_if.source                          rsp_chan,
   input  wire                                csr_we,
   input  wire [krs_pkg::CSR_IDX_W-1:0]       csr_idx,
   input  wire [krs_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import krs_pkg::*;

   state_type           state_ff, state_in;
   cell_op_type         mark_op_ff, mark_op_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [KSTEP_W-1:0]  step_ff, step_in;
   logic [RAD_W-1:0]    r_ff, r_in;
   logic [RR_W-1:0]     rr_ff, rr_in;
   logic [RR_W-1:0]     sel_rr_ff, sel_rr_in;
   logic [IDX_W-1:0]    emit_ff, emit_in;
   logic [KEEP_W-1:0]   keep_count_ff, keep_count_in;
   logic [RAD_W-1:0]    radius_limit_ff, radius_limit_in;

   cell_ctrl_type       ctrl;
   srch_type            srch_head;
   trav_type            trav_w [MAX_POINTS];
   srch_type            srch_w [MAX_POINTS];
   logic                keep_w [MAX_POINTS];
   logic [CNT_W-1:0]    n_fin;

   // Chain of cells: points rotate as a ring, probes and flags shift down.
   for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
      krs_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_id  (IDX_W'(i)),
         .ctrl     (ctrl),
         .trav_in  (trav_w[(i + 1) % MAX_POINTS]),
         .trav_out (trav_w[i]),
         .srch_in  ((i == 0) ? srch_head : srch_w[(i + MAX_POINTS - 1) % MAX_POINTS]),
         .srch_out (srch_w[i]),
         .keep_in  ((i == MAX_POINTS - 1) ? 1'b0 : keep_w[(i + 1) % MAX_POINTS]),
         .keep_out (keep_w[i])
      );
   end

   // Channel outputs.
   assign req_chan.ready       = (state_ff == ST_LOAD);
   assign rsp_chan.valid       = (state_ff == ST_EMIT);
   assign rsp_chan.point_index = OUT_IDX_W'(emit_ff);
   assign rsp_chan.keep        = keep_w[0];
   assign rsp_chan.last_result = ((CNT_W'(emit_ff) + CNT_W'(1)) == cnt_ff);

   // Sequencer: load, rotate, radius search, mark, emit.
   always_comb begin
      state_in      = state_ff;
      mark_op_in    = mark_op_ff;
      cnt_in        = cnt_ff;
      step_in       = step_ff;
      r_in          = r_ff;
      rr_in         = rr_ff;
      sel_rr_in     = sel_rr_ff;
      emit_in       = emit_ff;
      n_fin         = cnt_ff;

      ctrl.op       = OP_NONE;
      ctrl.load_en  = 1'b0;
      ctrl.load_idx = IDX_W'(cnt_ff);
      ctrl.load_pt.x    = req_chan.pos_x;
      ctrl.load_pt.y    = req_chan.pos_y;
      ctrl.load_pt.lvl  = req_chan.level;
      ctrl.load_pt.resp = RESPONSE_BITS'(req_chan.response);
      ctrl.sel_rr   = sel_rr_ff;

      srch_head.valid = 1'b0;
      srch_head.last  = ((r_ff + RAD_W'(1)) == radius_limit_ff);
      srch_head.rr    = rr_ff;
      srch_head.cnt   = '0;

      case (state_ff)
         ST_LOAD: begin
            if (req_chan.valid) begin
               if (cnt_ff < CNT_W'(MAX_POINTS)) begin
                  ctrl.load_en = 1'b1;
                  n_fin        = cnt_ff + CNT_W'(1);
               end
               cnt_in = n_fin;
               if (req_chan.final_point) begin
                  step_in = '0;
                  if (CMP_W'(n_fin) <= CMP_W'(keep_count_ff)) begin
                     mark_op_in = OP_KEEP_ALL;
                     state_in   = ST_MARK;
                  end else begin
                     state_in = ST_KILL;
                  end
               end
            end
         end
         ST_KILL: begin
            step_in = step_ff + KSTEP_W'(1);
            r_in    = '0;
            rr_in   = '0;
            if (step_ff == '0) begin
               ctrl.op = OP_START;
            end else if (step_ff <= KSTEP_W'(MAX_POINTS)) begin
               ctrl.op = OP_ROTATE;
            end else if (radius_limit_ff == '0) begin
               mark_op_in = OP_KEEP_NONE;
               state_in   = ST_MARK;
            end else begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            ctrl.op = OP_SEARCH;
            if (r_ff < radius_limit_ff) begin
               srch_head.valid = 1'b1;
               r_in  = r_ff + RAD_W'(1);
               rr_in = rr_ff + RR_W'({r_ff, 1'b1});
            end
            if (srch_w[MAX_POINTS-1].valid) begin
               sel_rr_in = srch_w[MAX_POINTS-1].rr;
               if ((CMP_W'(srch_w[MAX_POINTS-1].cnt) <= CMP_W'(keep_count_ff))
                   || srch_w[MAX_POINTS-1].last) begin
                  mark_op_in = OP_KEEP_RR;
                  state_in   = ST_MARK;
               end
            end
         end
         ST_MARK: begin
            ctrl.op  = mark_op_ff;
            emit_in  = '0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_chan.ready) begin
               ctrl.op = OP_SHIFT;
               emit_in = emit_ff + IDX_W'(1);
               if (rsp_chan.last_result) begin
                  cnt_in   = '0;
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Configuration writes.
   always_comb begin
      keep_count_in   = keep_count_ff;
      radius_limit_in = radius_limit_ff;
      if (csr_we) begin
         case (csr_idx)
            CSR_KEEP_COUNT:   keep_count_in   = KEEP_W'(csr_wdata);
            CSR_RADIUS_LIMIT: radius_limit_in = RAD_W'(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_LOAD;
         mark_op_ff      <= OP_NONE;
         cnt_ff          <= '0;
         step_ff         <= '0;
         r_ff            <= '0;
         rr_ff           <= '0;
         emit_ff         <= '0;
         keep_count_ff   <= KEEP_COUNT_RST;
         radius_limit_ff <= RADIUS_LIMIT_RST;
      end else begin
         state_ff        <= state_in;
         mark_op_ff      <= mark_op_in;
         cnt_ff          <= cnt_in;
         step_ff         <= step_in;
         r_ff            <= r_in;
         rr_ff           <= rr_in;
         emit_ff         <= emit_in;
         keep_count_ff   <= keep_count_in;
         radius_limit_ff <= radius_limit_in;
      end
   end

   // Chosen squared radius.
   always_ff @(posedge clock) begin
      sel_rr_ff <= sel_rr_in;
   end

`ifndef ASSERT_OFF
   // Loading and reporting never overlap.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("keypoint and result beats overlap");

   // A decision always works on a non-empty set.
   a_set_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> (cnt_ff != '0))
      else $error("decision started on an empty set");

   // The last result beat returns the block to loading with an empty set.
   a_last_returns: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && rsp_chan.last_result)
      |=> (state_ff == ST_LOAD && cnt_ff == '0))
      else $error("set not closed after last result");

   // A probe never counts more survivors than points in the set.
   a_probe_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH && srch_w[MAX_POINTS-1].valid)
      |-> (srch_w[MAX_POINTS-1].cnt <= cnt_ff))
      else $error("survivor count exceeds set size");
`endif

endmodule

`default_nettype wire
